[rtl/pwc_pkg.sv]
// Shared types and constants of the pulse width capture block.
`default_nettype none

package pwc_pkg;

  // Field widths of the request and result payloads.
  localparam int CH_BITS   = 4;
  localparam int TICK_BITS = 24;
  localparam int MS_BITS   = 32;
  localparam int US_BITS   = 32;

  // Reset value of the tick reload register.
  localparam logic [TICK_BITS-1:0] TICK_RELOAD_RST = 24'd71999;

  // Microseconds per millisecond, and the width it needs.
  localparam int                 K_BITS    = 10;
  localparam logic [K_BITS-1:0]  US_PER_MS = 10'd1000;

  // One millisecond in ticks is reload plus one, so one bit more than a tick.
  localparam int ONE_MS_W = TICK_BITS + 1;
  // The tick remainder is at most a tick value plus one millisecond's worth, so it fits this width.
  localparam int SUB_W    = ONE_MS_W;
  // Dividend of the microsecond division: remainder times 1000.
  localparam int DVD_W    = SUB_W + K_BITS;
  // Whole milliseconds times 1000, and the final sum before saturation.
  localparam int MSX_W    = MS_BITS + K_BITS;
  localparam int SUM_W    = MSX_W + 1;

  // Depth of the queue between the front and the back.
  localparam int QUEUE_DEPTH = 2;

  // One edge event.
  typedef struct packed {
    logic [CH_BITS-1:0]   channel;
    logic [TICK_BITS-1:0] tick_now;
    logic [MS_BITS-1:0]   ms_now;
  } pwc_in_t;

  // One measurement result.
  typedef struct packed {
    logic [CH_BITS-1:0] out_channel;
    logic               was_falling;
    logic [MS_BITS-1:0] period_ms;
    logic [US_BITS-1:0] width_us;
  } pwc_out_t;

  // Classified event handed from the front to the back.
  typedef struct packed {
    logic [CH_BITS-1:0]   channel;
    logic                 is_fall;
    logic [MS_BITS-1:0]   ms_diff;
    logic [TICK_BITS-1:0] saved_tick;
    logic [TICK_BITS-1:0] tick;
  } pwc_cmd_t;

  // Sequencer states of the back end.
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_PREP,
    BK_DIV,
    BK_SUM
  } pwc_back_state_t;

endpackage

`default_nettype wire

[rtl/pwc_front.sv]
// Front end: accepts edge events, keeps per-channel state and classifies each event.
`default_nettype none

module pwc_front
  import pwc_pkg::*;
#(
  parameter int NUM_CHANNELS = 16
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  input  wire pwc_in_t  in_data,
  output logic          in_stall,
  input  wire logic     q_full,
  output logic          push,
  output pwc_cmd_t      push_data
);

  localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  logic [NUM_CHANNELS-1:0] expect_falling;
  logic [NUM_CHANNELS-1:0] stamp_valid;
  logic [MS_BITS-1:0]      rise_ms_stamp   [NUM_CHANNELS];
  logic [TICK_BITS-1:0]    rise_tick_stamp [NUM_CHANNELS];

  logic                 in_range;
  logic [IDX_W-1:0]     ch_idx;
  logic                 cur_fall;
  logic [MS_BITS-1:0]   ms_stamp;
  logic [TICK_BITS-1:0] tick_stamp;
  logic                 take;

  // Handshake: the queue having room is all that gates a new request.
  assign in_stall = q_full;
  assign take     = in_valid && !q_full;
  assign push     = take;

  // Look up the channel; a stamp never written reads as zero.
  always_comb begin
    in_range   = (32'(in_data.channel) < NUM_CHANNELS);
    ch_idx     = IDX_W'(in_data.channel);
    cur_fall   = in_range && expect_falling[ch_idx];
    ms_stamp   = (in_range && stamp_valid[ch_idx]) ? rise_ms_stamp[ch_idx] : '0;
    tick_stamp = (in_range && stamp_valid[ch_idx]) ? rise_tick_stamp[ch_idx] : '0;
  end

  // Build the command for the back end.
  always_comb begin
    push_data.channel    = in_data.channel;
    push_data.is_fall    = cur_fall;
    push_data.ms_diff    = in_range ? (ms_stamp - in_data.ms_now) : '0;
    push_data.saved_tick = tick_stamp;
    push_data.tick       = in_data.tick_now;
  end

  // Edge flags and stamp valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      expect_falling <= '0;
      stamp_valid    <= '0;
    end else if (take && in_range) begin
      expect_falling[ch_idx] <= !cur_fall;
      if (!cur_fall) begin
        stamp_valid[ch_idx] <= 1'b1;
      end
    end
  end

  // Time stamps of the last rising edge.
  always_ff @(posedge clk) begin
    if (take && in_range && !cur_fall) begin
      rise_ms_stamp[ch_idx]   <= in_data.ms_now;
      rise_tick_stamp[ch_idx] <= in_data.tick_now;
    end
  end

endmodule

`default_nettype wire

[rtl/pwc_queue.sv]
// Short queue of classified events between the front and the back end.
`default_nettype none

module pwc_queue
  import pwc_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     push,
  input  wire pwc_cmd_t push_data,
  output logic          full,
  input  wire logic     pop,
  output pwc_cmd_t      pop_data,
  output logic          empty
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  pwc_cmd_t         entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full     = (count == CNT_W'(QUEUE_DEPTH));
  assign empty    = (count == '0);
  assign pop_data = entries[rd_ptr];

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // The front never writes a full queue and the back never reads an empty one.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("queue read while empty");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
      count <= CNT_W'(QUEUE_DEPTH))
    else $error("queue count out of range");

endmodule

`default_nettype wire

[rtl/pwc_div.sv]
// Bit-serial restoring divider for the microsecond remainder term.
`default_nettype none

module pwc_div
  import pwc_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  input  wire logic [DVD_W-1:0]    dividend,
  input  wire logic [ONE_MS_W-1:0] divisor,
  output logic                     busy,
  output logic                     done,
  output logic [DVD_W-1:0]         quotient
);

  localparam int CNT_W = $clog2(DVD_W);

  logic [DVD_W-1:0]    q;
  logic [ONE_MS_W-1:0] rem;
  logic [ONE_MS_W-1:0] dvs;
  logic [CNT_W-1:0]    count;
  logic [ONE_MS_W:0]   trial;
  logic                fits;
  logic [ONE_MS_W:0]   diff;

  assign quotient = q;

  // One quotient bit per cycle: shift in the next dividend bit and try a subtract.
  always_comb begin
    trial = {rem, q[DVD_W-1]};
    fits  = (trial >= {1'b0, dvs});
    diff  = trial - {1'b0, dvs};
  end

  // Control.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= '0;
      end else if (busy) begin
        count <= count + 1'b1;
        if (count == CNT_W'(DVD_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath.
  always_ff @(posedge clk) begin
    if (start) begin
      q   <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      q   <= {q[DVD_W-2:0], fits};
      rem <= fits ? diff[ONE_MS_W-1:0] : trial[ONE_MS_W-1:0];
    end
  end

endmodule

`default_nettype wire

[rtl/pwc_back.sv]
// Back end: turns classified events into results and owns the output register.
`default_nettype none

module pwc_back
  import pwc_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic [TICK_BITS-1:0] tick_reload,
  input  wire logic                 q_empty,
  input  wire pwc_cmd_t             q_data,
  output logic                      pop,
  output logic                      out_valid,
  output pwc_out_t                  out_data,
  input  wire logic                 out_stall
);

  pwc_back_state_t state;
  pwc_back_state_t state_next;

  pwc_cmd_t            cmd;
  logic [MSX_W-1:0]    ms_x1000;
  logic [MSX_W-1:0]    ms_x1000_next;
  logic                out_free;
  logic                load_out;
  pwc_out_t            out_next;

  logic [ONE_MS_W-1:0] one_ms;
  logic                ms_nz;
  logic [MS_BITS-1:0]  ms_adj;
  logic [SUB_W-1:0]    start_tick;
  logic [SUB_W-1:0]    now_tick;
  logic [SUB_W-1:0]    sub;
  logic [DVD_W-1:0]    sub_x1000;
  logic [SUM_W-1:0]    total;

  logic                div_start;
  logic                div_busy;
  logic                div_done;
  logic [DVD_W-1:0]    quot;

  assign out_free = !out_valid || !out_stall;

  // Borrow one millisecond into the tick term when any millisecond passed.
  always_comb begin
    one_ms        = {1'b0, tick_reload} + 1'b1;
    ms_nz         = (cmd.ms_diff != '0);
    ms_adj        = ms_nz ? (cmd.ms_diff - 1'b1) : cmd.ms_diff;
    start_tick    = SUB_W'(cmd.saved_tick) + (ms_nz ? one_ms : '0);
    now_tick      = SUB_W'(cmd.tick);
    sub           = (start_tick >= now_tick) ? (start_tick - now_tick) : '0;
    sub_x1000     = DVD_W'(sub) * DVD_W'(US_PER_MS);
    ms_x1000_next = MSX_W'(ms_adj) * MSX_W'(US_PER_MS);
    total         = SUM_W'(ms_x1000) + SUM_W'(quot);
  end

  pwc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (sub_x1000),
    .divisor  (one_ms),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (quot)
  );

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequencer: next state, queue pop, divider start and result load.
  always_comb begin
    state_next = state;
    pop        = 1'b0;
    div_start  = 1'b0;
    load_out   = 1'b0;
    out_next   = '0;
    unique case (state)
      BK_IDLE: begin
        if (!q_empty) begin
          if (q_data.is_fall) begin
            pop        = 1'b1;
            state_next = BK_PREP;
          end else if (out_free) begin
            // Rising edge or unknown channel: the result is ready at once.
            pop                  = 1'b1;
            load_out             = 1'b1;
            out_next.out_channel = q_data.channel;
            out_next.period_ms   = q_data.ms_diff;
          end
        end
      end
      BK_PREP: begin
        div_start  = 1'b1;
        state_next = BK_DIV;
      end
      BK_DIV: begin
        if (div_done) begin
          state_next = BK_SUM;
        end
      end
      BK_SUM: begin
        out_next.out_channel = cmd.channel;
        out_next.was_falling = 1'b1;
        out_next.width_us    = (total[SUM_W-1:US_BITS] != '0) ? '1 : total[US_BITS-1:0];
        if (out_free) begin
          load_out   = 1'b1;
          state_next = BK_IDLE;
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  // Working copy of the falling-edge command and the whole-millisecond term.
  always_ff @(posedge clk) begin
    if (pop) begin
      cmd <= q_data;
    end
    if (state == BK_PREP) begin
      ms_x1000 <= ms_x1000_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data <= out_next;
    end
  end

  // A rising-edge result carries no width and a falling-edge result no period.
  a_rise_no_width: assert property (@(posedge clk) disable iff (rst)
      out_valid && !out_data.was_falling |-> out_data.width_us == '0)
    else $error("rising-edge result with nonzero width");
  a_fall_no_period: assert property (@(posedge clk) disable iff (rst)
      out_valid && out_data.was_falling |-> out_data.period_ms == '0)
    else $error("falling-edge result with nonzero period");
  a_div_done_sum: assert property (@(posedge clk) disable iff (rst)
      state == BK_DIV && div_done |=> state == BK_SUM)
    else $error("divider finished but sequencer did not move to the sum");
  a_div_start_idle: assert property (@(posedge clk) disable iff (rst)
      div_start |-> !div_busy)
    else $error("divider started while busy");

endmodule

`default_nettype wire

[rtl/pulse_width_capture_core.sv]
// PWM input capture over several channels: edge events in, period and high-time results out.
// Each request is one edge on one channel with the tick and millisecond counter values at that
// edge. A rising edge yields the period in milliseconds since the previous rising edge of the
// channel; a falling edge yields the high time in microseconds, saturated at 2^32-1. A channel
// at or above NUM_CHANNELS gives a zero result and leaves all state alone. Requests pass through
// a two-entry queue; a rising edge or unknown channel goes on to the output register, one per
// cycle while the back end is idle and not stalled. A falling edge holds the back end in PREP,
// DIV and SUM as the bit-serial divider makes one of 35 quotient bits per cycle. The tick
// reload register is always ready and should be written only while no request is pending.
`default_nettype none

module pulse_width_capture_core
  import pwc_pkg::*;
#(
  parameter int NUM_CHANNELS = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  input  wire pwc_in_t              in_data,
  output logic                      in_stall,
  output logic                      out_valid,
  output pwc_out_t                  out_data,
  input  wire logic                 out_stall,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [TICK_BITS-1:0] cfg_data
);

  logic [TICK_BITS-1:0] tick_reload;
  logic                 q_full;
  logic                 q_empty;
  logic                 push;
  logic                 pop;
  pwc_cmd_t             push_data;
  pwc_cmd_t             pop_data;

  // Configuration register.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_reload <= TICK_RELOAD_RST;
    end else if (cfg_valid && cfg_ready) begin
      tick_reload <= cfg_data;
    end
  end

  pwc_front #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .in_stall  (in_stall),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  pwc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (q_empty)
  );

  pwc_back u_back (
    .clk         (clk),
    .rst         (rst),
    .tick_reload (tick_reload),
    .q_empty     (q_empty),
    .q_data      (pop_data),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_data    (out_data),
    .out_stall   (out_stall)
  );

endmodule

`default_nettype wire

[verif/pulse_width_capture_core_test.sv]
// Self-checking testbench for the pulse width capture core with a built-in result predictor.
`timescale 1ns / 100ps

module pulse_width_capture_core_test
  import pwc_pkg::*;
;

  localparam int NUM_CH       = 16;
  localparam int HOLD_CYCLES  = 150;
  localparam int QUIET_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 60;
  localparam int PHASE_ITEMS  = 76;
  localparam int NUM_PHASES   = 5;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid;
  pwc_in_t              in_data;
  logic                 in_stall;
  logic                 out_valid;
  pwc_out_t             out_data;
  logic                 out_stall;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [TICK_BITS-1:0] cfg_data;

  // Idle controls shared by the request and result sides.
  bit tx_idle_en;
  bit rx_idle_en;
  bit hold_off_req;
  int quiet_cycles;

  // Tracks channel state, predicts each result and checks what comes out.
  class capture_scoreboard;
    bit [TICK_BITS-1:0] reload;
    bit                 armed[NUM_CH];
    bit [MS_BITS-1:0]   rise_ms[NUM_CH];
    bit [TICK_BITS-1:0] rise_tick[NUM_CH];
    pwc_out_t           expected_q[$];
    int                 errors;

    function new();
      reload = TICK_RELOAD_RST;
      errors = 0;
      foreach (armed[i]) begin
        armed[i]     = 1'b0;
        rise_ms[i]   = '0;
        rise_tick[i] = '0;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // High time in microseconds, with a one millisecond borrow when any has passed.
    function bit [US_BITS-1:0] high_time_us(bit [MS_BITS-1:0] ms_diff,
                                            bit [TICK_BITS-1:0] saved,
                                            bit [TICK_BITS-1:0] tick);
      longint unsigned one_ms, ms, start, sub, total;
      one_ms = 64'(reload);
      one_ms = one_ms + 1;
      ms     = 64'(ms_diff);
      start  = 64'(saved);
      if (ms != 0) begin
        ms    = ms - 1;
        start = start + one_ms;
      end
      sub   = (start >= 64'(tick)) ? start - 64'(tick) : 64'd0;
      sub   = (sub * 1000) / one_ms;
      total = ms * 1000 + sub;
      if (total > 64'hFFFF_FFFF) begin
        return '1;
      end
      return total[US_BITS-1:0];
    endfunction

    // An accepted request updates the channel state and queues its result.
    function void note_request(pwc_in_t r);
      pwc_out_t res;
      res = '0;
      res.out_channel = r.channel;
      if (r.channel < NUM_CH) begin
        if (!armed[r.channel]) begin
          res.period_ms        = rise_ms[r.channel] - r.ms_now;
          rise_ms[r.channel]   = r.ms_now;
          rise_tick[r.channel] = r.tick_now;
          armed[r.channel]     = 1'b1;
        end else begin
          res.was_falling  = 1'b1;
          res.width_us     = high_time_us(rise_ms[r.channel] - r.ms_now,
                                          rise_tick[r.channel], r.tick_now);
          armed[r.channel] = 1'b0;
        end
      end
      expected_q.push_back(res);
    endfunction

    // Only the first hundred mismatches are printed, but all are counted.
    task report(string what);
      if (errors < 100) begin
        $display("ERROR at %0t: %s", $realtime, what);
      end
      errors++;
    endtask

    task check_result(pwc_out_t got);
      pwc_out_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("result on channel %0d with no request waiting", got.out_channel));
        return;
      end
      want = expected_q.pop_front();
      if (got.out_channel !== want.out_channel)
        report($sformatf("out_channel got %0d expected %0d", got.out_channel,
                         want.out_channel));
      if (got.was_falling !== want.was_falling)
        report($sformatf("was_falling on channel %0d got %0b expected %0b",
                         want.out_channel, got.was_falling, want.was_falling));
      if (got.period_ms !== want.period_ms)
        report($sformatf("period_ms on channel %0d got %0d expected %0d",
                         want.out_channel, got.period_ms, want.period_ms));
      if (got.width_us !== want.width_us)
        report($sformatf("width_us on channel %0d got %0d expected %0d",
                         want.out_channel, got.width_us, want.width_us));
    endtask

    task check_drained();
      while (expected_q.size() != 0) begin
        report($sformatf("result for channel %0d never arrived",
                         expected_q[0].out_channel));
        void'(expected_q.pop_front());
      end
    endtask
  endclass

  capture_scoreboard sb;

  pulse_width_capture_core #(
    .NUM_CHANNELS(NUM_CH)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_data  (in_data),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_data (out_data),
    .out_stall(out_stall),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  // 10 ns clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result side: random stall bursts, and one long hold-off on demand.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_stall <= 1'b0;
      end else if (rx_idle_en && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 6)) @(negedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Results are checked as they are accepted.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      sb.check_result(out_data);
    end
  end

  // Watchdog on cycles in which no request, result or register write moves.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic pwc_in_t edge_at(int ch, bit [TICK_BITS-1:0] tick, bit [MS_BITS-1:0] ms);
    pwc_in_t r;
    r.channel  = CH_BITS'(ch);
    r.tick_now = tick;
    r.ms_now   = ms;
    return r;
  endfunction

  // Mostly well-formed edges that follow each channel's last rising stamp, some noise.
  function automatic pwc_in_t pwm_edge();
    pwc_in_t          r;
    int unsigned      ch;
    int unsigned      pick;
    bit [MS_BITS-1:0] gap;
    ch        = $urandom_range(0, NUM_CH - 1);
    r.channel = CH_BITS'(ch);
    pick      = $urandom_range(0, 99);
    if (pick < 15) begin
      r.tick_now = TICK_BITS'($urandom);
      r.ms_now   = $urandom;
      return r;
    end
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      gap = $urandom_range(0, 3);
    end else if (pick < 85) begin
      gap = $urandom_range(4, 5000);
    end else if (pick < 95) begin
      // Around the point where the high time no longer fits in 32 bits.
      gap = $urandom_range(4290000, 4300000);
    end else begin
      gap = $urandom;
    end
    r.ms_now = sb.rise_ms[ch] - gap;
    if (sb.armed[ch] && gap == 0) begin
      r.tick_now = TICK_BITS'($urandom_range(0, sb.rise_tick[ch]));
    end else begin
      r.tick_now = TICK_BITS'($urandom_range(0, sb.reload));
    end
    return r;
  endfunction

  // Offers one request until it is taken, then maybe idles for a burst.
  task automatic send_request(input pwc_in_t r);
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= r;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    sb.note_request(r);
    if (tx_idle_en && $urandom_range(0, 3) == 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6) - 1) @(negedge clk);
    end
  endtask

  // Writes the tick reload once every outstanding result has come back.
  task automatic write_reload(input bit [TICK_BITS-1:0] value);
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    sb.reload = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    bit [TICK_BITS-1:0] reload_val;
    in_valid   = 1'b0;
    in_data    = '0;
    cfg_valid  = 1'b0;
    cfg_data   = '0;
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    sb = new();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed edges at the default reload.
    send_request(edge_at(0, 24'd0, 32'd0));
    send_request(edge_at(0, 24'd0, 32'd0));
    // No millisecond elapsed.
    send_request(edge_at(1, 24'd50000, 32'd100));
    send_request(edge_at(1, 24'd20000, 32'd100));
    // Milliseconds elapsed, one borrowed into the tick term.
    send_request(edge_at(2, 24'd10000, 32'd100));
    send_request(edge_at(2, 24'd60000, 32'd97));
    // Tick counter above the stamp: tick term clamps to zero.
    send_request(edge_at(3, 24'd100, 32'd5));
    send_request(edge_at(3, 24'd5000, 32'd5));
    // Field extremes, and a width far beyond 32 bits.
    send_request(edge_at(4, 24'hFF_FFFF, 32'hFFFF_FFFF));
    send_request(edge_at(4, 24'd0, 32'd0));
    // Just over and just under the saturation point.
    send_request(edge_at(5, 24'd71999, 32'd4294968));
    send_request(edge_at(5, 24'd71999, 32'd0));
    send_request(edge_at(6, 24'd0, 32'd4294967));
    send_request(edge_at(6, 24'd0, 32'd0));
    // Millisecond counter wrapping between stamps.
    send_request(edge_at(15, 24'd0, 32'd0));
    send_request(edge_at(15, 24'hFF_FFFF, 32'hFFFF_FFFF));
    send_request(edge_at(15, 24'd1, 32'h8000_0000));

    // Random phases, each at its own reload; the last one runs without idling.
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0:       reload_val = '0;
        1:       reload_val = '1;
        2:       reload_val = 24'd999;
        3:       reload_val = TICK_BITS'($urandom_range(1, 24'hFF_FFFE));
        default: reload_val = TICK_RELOAD_RST;
      endcase
      write_reload(reload_val);
      if (p == NUM_PHASES - 1) begin
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
      end
      // Fill the block against a long result hold-off.
      if (p == 2) begin
        hold_off_req = 1'b1;
      end
      repeat (PHASE_ITEMS) send_request(pwm_edge());
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    sb.check_drained();
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[pulse_width_capture_core.f]
rtl/pwc_pkg.sv
rtl/pwc_front.sv
rtl/pwc_queue.sv
rtl/pwc_div.sv
rtl/pwc_back.sv
rtl/pulse_width_capture_core.sv
verif/pulse_width_capture_core_test.sv
